/* design/ucs2cp_pkg.sv */
`default_nettype none

package ucs2cp_pkg;

  localparam int unsigned NumDigits = 5;
  localparam int unsigned NumDivStages = NumDigits - 1;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_QUEST = 8'h3F;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [15:0] CYR_IO_UPPER = 16'd1025;
  localparam logic [15:0] CYR_IO_LOWER = 16'd1105;
  localparam logic [7:0]  CP_IO_UPPER  = 8'd168;
  localparam logic [7:0]  CP_IO_LOWER  = 8'd184;
  localparam logic [15:0] CYR_OFFSET   = 16'd848;
  localparam logic [7:0]  CYR_PAGE     = 8'h04;

  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic                      esc;
    logic [7:0]                chr;
    logic [2:0]                nd;
    logic [15:0]               rem;
    logic [NumDigits-1:0][3:0] dig;
  } pipe_t;

endpackage

`default_nettype wire

/* design/ucs2_to_cp1251_escaped_core.sv */
`default_nettype none

// Converts one UCS-2 code unit per item into CP1251 bytes. A code unit that maps to a
// single CP1251 byte leaves as one byte, bytes below 0x20 replaced by '?'; any other unit
// leaves as "<#", its decimal value and "#>", seven to nine bytes. A classify stage and
// four divide-by-ten stages, each peeling off one decimal digit, let a new item enter in
// every cycle unless the serializer holds the pipeline; the one output serializer sends one
// byte per cycle while m_axis_tready_i allows, and an escaped unit with d decimal digits
// leaves as d + 4 bytes. tlast marks the final byte of each code unit.
module ucs2_to_cp1251_escaped_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // code_unit [15:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // out_byte [7:0]
  output logic             m_axis_tlast_o
);

  localparam int unsigned NS = ucs2cp_pkg::NumDivStages + 1;

  ucs2cp_pkg::pipe_t st_q [NS];
  ucs2cp_pkg::pipe_t st_d [NS];
  logic [NS-1:0]     st_v_q;
  logic [NS:0]       rdy;

  ucs2cp_pkg::pipe_t ser_q, ser_d;
  logic              ser_v_q;
  logic [3:0]        idx_q;
  logic [3:0]        ser_len;
  logic              ser_last;
  logic              ser_ready;
  logic              out_load;
  logic [7:0]        ser_chr;
  logic [3:0]        dsel_full;
  logic [2:0]        dsel;

  logic              out_v_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;

  // Input classification and Cyrillic remap.
  logic [15:0] unit;
  logic [15:0] code;
  always_comb begin
    unit = s_axis_tdata_i;
    code = unit;
    if (unit[15:8] == ucs2cp_pkg::CYR_PAGE) begin
      priority if (unit == ucs2cp_pkg::CYR_IO_UPPER) begin
        code = {8'd0, ucs2cp_pkg::CP_IO_UPPER};
      end else if (unit == ucs2cp_pkg::CYR_IO_LOWER) begin
        code = {8'd0, ucs2cp_pkg::CP_IO_LOWER};
      end else begin
        code = unit - ucs2cp_pkg::CYR_OFFSET;
      end
    end
    st_d[0]     = '0;
    st_d[0].esc = (code[15:8] != 8'd0);
    st_d[0].chr = (code[7:0] < ucs2cp_pkg::CHAR_SPACE) ? ucs2cp_pkg::CHAR_QUEST : code[7:0];
    st_d[0].rem = unit;
    priority if (unit >= 16'd10000) begin
      st_d[0].nd = 3'd5;
    end else if (unit >= 16'd1000) begin
      st_d[0].nd = 3'd4;
    end else if (unit >= 16'd100) begin
      st_d[0].nd = 3'd3;
    end else if (unit >= 16'd10) begin
      st_d[0].nd = 3'd2;
    end else begin
      st_d[0].nd = 3'd1;
    end
  end

  // One decimal digit per stage.
  for (genvar k = 1; k < NS; k++) begin : g_div
    logic [31:0] prod;
    logic [12:0] quo;
    logic [15:0] back;
    logic [15:0] rmd;
    always_comb begin
      prod = st_q[k-1].rem * ucs2cp_pkg::DIV10_RECIP;
      quo  = prod[ucs2cp_pkg::DIV10_SHIFT +: 13];
      back = {quo, 3'd0} + {2'd0, quo, 1'b0};
      rmd  = st_q[k-1].rem - back;
      st_d[k]          = st_q[k-1];
      st_d[k].dig[k-1] = rmd[3:0];
      st_d[k].rem      = {3'd0, quo};
    end
  end

  always_comb begin
    rdy[NS] = ser_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !st_v_q[k] || rdy[k+1];
    end
  end
  assign s_axis_tready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else begin
      if (rdy[0]) begin
        st_v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          st_v_q[k] <= st_v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Output serializer.
  assign ser_len   = ser_q.esc ? ({1'b0, ser_q.nd} + 4'd4) : 4'd1;
  assign ser_last  = (idx_q == ser_len - 4'd1);
  assign out_load  = ser_v_q && (!out_v_q || m_axis_tready_i);
  assign ser_ready = !ser_v_q || (out_load && ser_last);
  assign dsel_full = {1'b0, ser_q.nd} + 4'd1 - idx_q;
  assign dsel      = dsel_full[2:0];

  always_comb begin
    ser_d                                   = st_q[NS-1];
    ser_d.dig[ucs2cp_pkg::NumDigits-1]      = st_q[NS-1].rem[3:0];
  end

  always_comb begin
    priority if (!ser_q.esc) begin
      ser_chr = ser_q.chr;
    end else if (idx_q == 4'd0) begin
      ser_chr = ucs2cp_pkg::CHAR_LT;
    end else if (idx_q == 4'd1) begin
      ser_chr = ucs2cp_pkg::CHAR_HASH;
    end else if (ser_last) begin
      ser_chr = ucs2cp_pkg::CHAR_GT;
    end else if (idx_q == ser_len - 4'd2) begin
      ser_chr = ucs2cp_pkg::CHAR_HASH;
    end else begin
      unique case (dsel)
        3'd0:    ser_chr = ucs2cp_pkg::CHAR_ZERO | {4'd0, ser_q.dig[0]};
        3'd1:    ser_chr = ucs2cp_pkg::CHAR_ZERO | {4'd0, ser_q.dig[1]};
        3'd2:    ser_chr = ucs2cp_pkg::CHAR_ZERO | {4'd0, ser_q.dig[2]};
        3'd3:    ser_chr = ucs2cp_pkg::CHAR_ZERO | {4'd0, ser_q.dig[3]};
        3'd4:    ser_chr = ucs2cp_pkg::CHAR_ZERO | {4'd0, ser_q.dig[4]};
        default: ser_chr = ucs2cp_pkg::CHAR_QUEST;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (ser_ready) begin
        ser_v_q <= st_v_q[NS-1];
        idx_q   <= '0;
      end else if (out_load) begin
        idx_q <= idx_q + 4'd1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_ready) begin
      ser_q <= ser_d;
    end
    if (out_load) begin
      out_byte_q <= ser_chr;
      out_last_q <= ser_last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

/* design/ucs2cp_checker.sv */
`default_nettype none

module ucs2cp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [15:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [7:0]  m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // A stalled output item keeps its byte and its last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  // Bytes below 0x20 are never sent.
  a_no_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o >= ucs2cp_pkg::CHAR_SPACE)
    else $error("control byte on output");

  // An escape opener is followed by a hash on the next accepted byte.
  a_open_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o &&
      m_axis_tdata_o == ucs2cp_pkg::CHAR_LT ##1 m_axis_tvalid_o |->
      m_axis_tdata_o == ucs2cp_pkg::CHAR_HASH)
    else $error("escape opener not followed by hash");

  // A byte that closes an escape is always the last byte of its code unit.
  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o != ucs2cp_pkg::CHAR_GT)
    else $error("escape closer not marked last");

endmodule

bind ucs2_to_cp1251_escaped_core ucs2cp_checker u_ucs2cp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
